[rtl/decimal_text_to_fixed_point_core_defines.svh]
// Assertion helpers for the decimal text to fixed point core.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_CORE_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DTFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtfp assertion failed");

// Next-cycle implication, disabled during reset.
`define DTFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtfp assertion failed");

`endif

[rtl/dtfp_pkg.sv]
package dtfp_pkg;

  localparam int SCALE_DIGITS = 8;
  localparam int CHAR_W       = 8;
  localparam int INT_W        = 37;
  localparam int VALUE_W      = 64;
  localparam int CNT_W        = $clog2(SCALE_DIGITS + 1);

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int k = 0; k < n; k++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam longint unsigned SCALE = pow10(SCALE_DIGITS);
  localparam int FRAC_W = $clog2(SCALE);

  // Integer part is split in two halves for the scale multiply
  localparam int LO_W   = (INT_W + 1) / 2;
  localparam int HI_W   = INT_W - LO_W;
  localparam int PROD_W = INT_W + FRAC_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CMP_W  = (SUM_W > VALUE_W) ? SUM_W : VALUE_W;

  // Weight of each fraction digit position; the entry past the last is unused
  typedef logic [SCALE_DIGITS:0][FRAC_W-1:0] weight_tab_t;

  function automatic weight_tab_t build_weights();
    weight_tab_t w;
    for (int k = 0; k <= SCALE_DIGITS; k++) begin
      if (k < SCALE_DIGITS) begin
        w[k] = FRAC_W'(pow10(SCALE_DIGITS - 1 - k));
      end else begin
        w[k] = '0;
      end
    end
    return w;
  endfunction

  localparam weight_tab_t DIGIT_WEIGHT = build_weights();

  // Collected string, handed to the finishing pipeline on the last request
  typedef struct packed {
    logic              neg;
    logic              good;
    logic [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac_part;
  } fin_req_t;

endpackage

[rtl/dtfp_parser.sv]
module dtfp_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dtfp_pkg::INT_W-1:0]   cfg_data_i,
  input  logic                         in_fire_i,
  input  logic [dtfp_pkg::CHAR_W-1:0]  character_i,
  input  logic                         has_char_i,
  input  logic                         last_i,
  output logic                         fin_valid_o,
  output dtfp_pkg::fin_req_t           fin_req_o
);
  import dtfp_pkg::*;

  typedef enum logic [1:0] {PH_START, PH_INT, PH_FRAC} phase_e;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [INT_W-1:0]  MAX_INT_RESET = 37'd92233720368;

  logic [INT_W-1:0]  max_int_q;
  phase_e            phase_q, phase_d, phase_n;
  logic              neg_q, neg_d, neg_n;
  logic [INT_W-1:0]  int_q, int_d, int_n;
  logic [FRAC_W-1:0] frac_q, frac_d, frac_n;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_n;
  logic              seen_q, seen_d, seen_n;
  logic              failed_q, failed_d, failed_n;

  logic              is_digit;
  logic [3:0]        digit;
  logic [INT_W+3:0]  int_ext, int_next;
  logic [FRAC_W+3:0] frac_sum;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_int_q <= MAX_INT_RESET;
    end else if (cfg_we_i) begin
      max_int_q <= cfg_data_i;
    end
  end

  // Digit arithmetic: acc*10 + d for the integer, weighted add for the fraction
  assign is_digit = (character_i >= CH_ZERO) && (character_i <= CH_NINE);
  assign digit    = character_i[3:0];
  assign int_ext  = (INT_W+4)'(int_q);
  assign int_next = (int_ext << 3) + (int_ext << 1) + (INT_W+4)'(digit);
  assign frac_sum = (FRAC_W+4)'(frac_q)
                  + (FRAC_W+4)'(digit) * (FRAC_W+4)'(DIGIT_WEIGHT[cnt_q]);

  // State after this character
  always_comb begin
    phase_n  = phase_q;
    neg_n    = neg_q;
    int_n    = int_q;
    frac_n   = frac_q;
    cnt_n    = cnt_q;
    seen_n   = seen_q;
    failed_n = failed_q;
    if (has_char_i && !failed_q) begin
      if (is_digit) begin
        seen_n = 1'b1;
        if (phase_q != PH_FRAC) begin
          phase_n = PH_INT;
          int_n   = int_next[INT_W-1:0];
          if (int_next > (INT_W+4)'(max_int_q)) begin
            failed_n = 1'b1;
          end
        end else if (cnt_q < CNT_W'(SCALE_DIGITS)) begin
          frac_n = frac_sum[FRAC_W-1:0];
          cnt_n  = CNT_W'(cnt_q + 1'b1);
        end
      end else if ((character_i == CH_PLUS || character_i == CH_MINUS)
                   && phase_q == PH_START) begin
        neg_n   = (character_i == CH_MINUS);
        phase_n = PH_INT;
      end else if (character_i == CH_DOT && phase_q != PH_FRAC) begin
        phase_n = PH_FRAC;
      end else begin
        failed_n = 1'b1;
      end
    end
  end

  // Last request restarts the string
  always_comb begin
    if (last_i) begin
      phase_d  = PH_START;
      neg_d    = 1'b0;
      int_d    = '0;
      frac_d   = '0;
      cnt_d    = '0;
      seen_d   = 1'b0;
      failed_d = 1'b0;
    end else begin
      phase_d  = phase_n;
      neg_d    = neg_n;
      int_d    = int_n;
      frac_d   = frac_n;
      cnt_d    = cnt_n;
      seen_d   = seen_n;
      failed_d = failed_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      neg_q    <= 1'b0;
      int_q    <= '0;
      frac_q   <= '0;
      cnt_q    <= '0;
      seen_q   <= 1'b0;
      failed_q <= 1'b0;
    end else if (in_fire_i) begin
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      int_q    <= int_d;
      frac_q   <= frac_d;
      cnt_q    <= cnt_d;
      seen_q   <= seen_d;
      failed_q <= failed_d;
    end
  end

  // Snapshot of the finished string
  assign fin_valid_o         = in_fire_i && last_i;
  assign fin_req_o.neg       = neg_n;
  assign fin_req_o.good      = !failed_n && seen_n;
  assign fin_req_o.int_part  = int_n;
  assign fin_req_o.frac_part = frac_n;

endmodule

[rtl/dtfp_finish.sv]
module dtfp_finish (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fin_valid_i,
  input  dtfp_pkg::fin_req_t                fin_req_i,
  output logic                              fin_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [dtfp_pkg::VALUE_W-1:0] value_o,
  output logic                              ok_o
);
  import dtfp_pkg::*;

  localparam logic [FRAC_W-1:0]  SCALE_V   = FRAC_W'(SCALE);
  localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic en0, en1, en2, en3;
  logic v0_q, v1_q, v2_q, v3_q;

  // Stage 0: captured string
  fin_req_t s0_q;

  // Stage 1: partial products
  logic [LO_W+FRAC_W-1:0] p_lo_q, p_lo_d;
  logic [HI_W+FRAC_W-1:0] p_hi_q, p_hi_d;
  logic [FRAC_W-1:0]      frac1_q;
  logic                   neg1_q, good1_q;

  // Stage 2: magnitude and range check
  logic [SUM_W-1:0]   sum;
  logic [CMP_W-1:0]   sum_ext;
  logic [VALUE_W-1:0] mag2_q;
  logic               neg2_q, ok2_q, ok2_d;

  // Stage 3: signed result
  logic [VALUE_W-1:0] value_q, value_d;
  logic               ok_q;

  // Pipeline advance: a stage loads when empty or when its content moves on
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign fin_ready_o = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= fin_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Integer part times 10^scale, in two halves
  assign p_lo_d = (LO_W+FRAC_W)'(s0_q.int_part[LO_W-1:0]) * (LO_W+FRAC_W)'(SCALE_V);
  assign p_hi_d = (HI_W+FRAC_W)'(s0_q.int_part[INT_W-1:LO_W]) * (HI_W+FRAC_W)'(SCALE_V);

  // Recombine, add the fraction, check against the signed 64-bit limit
  assign sum     = (SUM_W'(p_hi_q) << LO_W) + SUM_W'(p_lo_q) + SUM_W'(frac1_q);
  assign sum_ext = CMP_W'(sum);
  assign ok2_d   = good1_q && (sum_ext <= CMP_W'(VALUE_MAX));

  // Sign and failure zeroing
  always_comb begin
    if (!ok2_q) begin
      value_d = '0;
    end else if (neg2_q) begin
      value_d = VALUE_W'(~mag2_q + 1'b1);
    end else begin
      value_d = mag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) s0_q <= fin_req_i;
    if (en1) begin
      p_lo_q  <= p_lo_d;
      p_hi_q  <= p_hi_d;
      frac1_q <= s0_q.frac_part;
      neg1_q  <= s0_q.neg;
      good1_q <= s0_q.good;
    end
    if (en2) begin
      mag2_q <= sum_ext[VALUE_W-1:0];
      neg2_q <= neg1_q;
      ok2_q  <= ok2_d;
    end
    if (en3) begin
      value_q <= value_d;
      ok_q    <= ok2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign value_o     = $signed(value_q);
  assign ok_o        = ok_q;

endmodule

[rtl/decimal_text_to_fixed_point_core.sv]
// Decimal text to fixed point: one character request per cycle while in_stall_o is low.
// A string's result reaches the output register after its last accepted request passes
// the finishing pipeline stages in order: capture, multiply, add/check, sign.
// Input stalls only when all four finishing stages are full and the output stalls.
// Reset (rst_ni low, asynchronous) clears the parse state and the pipeline valids,
// and loads the integer limit with its default.
module decimal_text_to_fixed_point_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dtfp_pkg::INT_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dtfp_pkg::CHAR_W-1:0]         character_i,
  input  logic                                has_char_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dtfp_pkg::VALUE_W-1:0] value_o,
  output logic                                ok_o
);
  import dtfp_pkg::*;

`include "decimal_text_to_fixed_point_core_defines.svh"

  logic     in_fire;
  logic     fin_valid;
  logic     fin_ready;
  fin_req_t fin_req;

  // Request accepted
  assign in_stall_o = !fin_ready;
  assign in_fire    = in_valid_i && fin_ready;

  dtfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .character_i (character_i),
    .has_char_i  (has_char_i),
    .last_i      (last_i),
    .fin_valid_o (fin_valid),
    .fin_req_o   (fin_req)
  );

  dtfp_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_valid_i (fin_valid),
    .fin_req_i   (fin_req),
    .fin_ready_o (fin_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .ok_o        (ok_o)
  );

  // Failed strings report zero
  `DTFP_ASSERT_NOW(a_fail_zero, out_valid_o && !ok_o, value_o == '0)
  // Input backpressure only comes from a stalled result
  `DTFP_ASSERT_NOW(a_stall_src, in_stall_o, out_valid_o && out_stall_i)
  // A good result never reaches the most negative code
  `DTFP_ASSERT_NOW(a_ok_range, out_valid_o && ok_o, value_o != 64'sh8000_0000_0000_0000)
  // A stalled result stays put
  `DTFP_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(value_o) && $stable(ok_o))

endmodule
